// ===== rtl/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and the hex digit decode for the URL
// percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t       h;
    logic [7:0] t;
    h.ok  = 1'b1;
    h.val = 4'd0;
    t     = 8'd0;
    if (b >= CH_0 && b <= CH_9) begin
      t = b - CH_0;
    end else if (b >= CH_LA && b <= CH_LF) begin
      t = b - CH_LA + HEX_TEN;
    end else if (b >= CH_UA && b <= CH_UF) begin
      t = b - CH_UA + HEX_TEN;
    end else begin
      h.ok = 1'b0;
    end
    h.val = t[3:0];
    return h;
  endfunction

endpackage

// ===== rtl/url_percent_decoder_core.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// Streaming form-urlencoded decoder, one byte per item.
//
// Input channel: in_valid/in_stall carry in_byte and is_last. Result channel:
// res_valid/res_stall carry out_byte, out_valid and out_last. Every input
// item gives exactly one result item; out_valid marks results that carry a
// decoded character ('+' becomes space, %XX becomes its byte, escape bytes
// and broken escapes give out_valid 0 and out_byte 0).
// The input register takes each accepted item, which is decoded and moves
// on into the result register when that register is free. Throughput: one
// item per cycle while the receiver does not stall; the input register and
// the result register let a new item in while a finished result waits.
// Reset clears both register stages and returns the escape phase to normal
// text. When the receiver stalls, the result holds; the input register
// fills, and in_stall rises while both stages are full.
// ----------------------------------------------------------------------------
module url_percent_decoder_core import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  logic       s1_full;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       adv;
  logic [7:0] dec_byte;
  logic       dec_ok;

  assign adv      = s1_full & (~res_valid | ~res_stall);
  assign in_stall = s1_full & ~adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_full <= 1'b1;
    end else if (adv) begin
      s1_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
      s1_last <= is_last;
    end
  end

  upd_step u_step (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_byte  (s1_byte),
    .is_last  (s1_last),
    .res_byte (dec_byte),
    .res_ok   (dec_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte  <= dec_byte;
      out_valid <= dec_ok;
      out_last  <= s1_last;
    end
  end

endmodule

// ===== rtl/upd_step.sv =====
// ----------------------------------------------------------------------------
// upd_step
// Escape phase tracking and per-byte decode. Result is combinational from
// the current byte and state; state advances when adv is high.
// ----------------------------------------------------------------------------
module upd_step import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic [7:0] res_byte,
  output logic       res_ok
);

  phase_t     phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       high_ok, high_ok_next;
  hex_t       dig;

  assign dig = hex_decode(in_byte);

  always_comb begin
    phase_next       = PH_TEXT;
    high_nibble_next = high_nibble;
    high_ok_next     = high_ok;
    case (phase)
      PH_HIGH: begin
        phase_next       = PH_LOW;
        high_nibble_next = dig.val;
        high_ok_next     = dig.ok;
      end
      PH_LOW: begin
        phase_next       = PH_TEXT;
        high_nibble_next = 4'd0;
        high_ok_next     = 1'b0;
      end
      default: begin
        phase_next = (in_byte == CH_PERCENT) ? PH_HIGH : PH_TEXT;
      end
    endcase
    if (is_last) begin
      phase_next       = PH_TEXT;
      high_nibble_next = 4'd0;
      high_ok_next     = 1'b0;
    end
  end

  always_comb begin
    res_byte = 8'd0;
    res_ok   = 1'b0;
    case (phase)
      PH_HIGH: begin
        res_byte = 8'd0;
        res_ok   = 1'b0;
      end
      PH_LOW: begin
        res_ok   = high_ok & dig.ok;
        res_byte = (high_ok & dig.ok) ? {high_nibble, dig.val} : 8'd0;
      end
      default: begin
        if (in_byte == CH_PERCENT) begin
          res_byte = 8'd0;
          res_ok   = 1'b0;
        end else if (in_byte == CH_PLUS) begin
          res_byte = CH_SPACE;
          res_ok   = 1'b1;
        end else begin
          res_byte = in_byte;
          res_ok   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TEXT;
      high_nibble <= 4'd0;
      high_ok     <= 1'b0;
    end else if (adv) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      high_ok     <= high_ok_next;
    end
  end

endmodule

// ===== rtl/upd_checker.sv =====
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks for url_percent_decoder_core, bound to the top level.
// ----------------------------------------------------------------------------
module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       is_last,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       out_last
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_byte) &&
      $stable(out_valid) && $stable(out_last))
    else $error("result changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(is_last))
    else $error("input item changed while stalled");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_byte == 8'd0)
    else $error("dropped result carries nonzero byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> res_valid && res_stall)
    else $error("input stalled without a stalled result");

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_byte   (in_byte),
  .is_last   (is_last),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .out_byte  (out_byte),
  .out_valid (out_valid),
  .out_last  (out_last)
);

// ===== sim/url_decode_checker.sv =====
// ----------------------------------------------------------------------------
// url_decode_checker
// Watches both channels of the URL percent decoder. It predicts the result
// of every accepted input item, queues the prediction, and compares each
// accepted result field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module url_decode_checker import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  input  logic       res_valid,
  input  logic       res_stall,
  input  logic [7:0] out_byte,
  input  logic       out_valid,
  input  logic       out_last,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } decoded_t;

  decoded_t   decoded_q[$];
  phase_t     phase;
  logic [3:0] hi_nib;
  logic       hi_ok;

  // 16 flags a non-hex character
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd16;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = c - CH_LA + HEX_TEN;
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = c - CH_UA + HEX_TEN;
    end
    return v[4:0];
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    phase      = PH_TEXT;
    hi_nib     = '0;
    hi_ok      = 1'b0;
  end

  always @(posedge clk) begin
    decoded_t   got;
    decoded_t   want;
    decoded_t   predicted;
    logic [4:0] d;
    if (rst) begin
      phase  = PH_TEXT;
      hi_nib = '0;
      hi_ok  = 1'b0;
      decoded_q.delete();
    end else begin
      if (res_valid && !res_stall) begin
        got = {out_byte, out_valid, out_last};
        if (decoded_q.size() == 0) begin
          fail_count++;
          $error("unexpected result item: out_byte %02h out_valid %0b out_last %0b",
                 out_byte, out_valid, out_last);
        end else begin
          want = decoded_q.pop_front();
          if (got.data !== want.data) begin
            fail_count++;
            $error("out_byte: expected %02h, got %02h", want.data, got.data);
          end
          if (got.valid !== want.valid) begin
            fail_count++;
            $error("out_valid: expected %0b, got %0b", want.valid, got.valid);
          end
          if (got.last !== want.last) begin
            fail_count++;
            $error("out_last: expected %0b, got %0b", want.last, got.last);
          end
        end
      end

      if (in_valid && !in_stall) begin
        predicted      = '0;
        predicted.last = is_last;
        case (phase)
          PH_HIGH: begin
            d      = digit_of(in_byte);
            hi_ok  = !d[4];
            hi_nib = d[3:0];
            phase  = PH_LOW;
          end
          PH_LOW: begin
            d = digit_of(in_byte);
            if (hi_ok && !d[4]) begin
              predicted.data  = {hi_nib, d[3:0]};
              predicted.valid = 1'b1;
            end
            phase  = PH_TEXT;
            hi_nib = '0;
            hi_ok  = 1'b0;
          end
          default: begin
            phase = PH_TEXT;
            if (in_byte == CH_PERCENT) begin
              phase = PH_HIGH;
            end else if (in_byte == CH_PLUS) begin
              predicted.data  = CH_SPACE;
              predicted.valid = 1'b1;
            end else begin
              predicted.data  = in_byte;
              predicted.valid = 1'b1;
            end
          end
        endcase
        // end of string drops any open escape
        if (is_last) begin
          phase  = PH_TEXT;
          hi_nib = '0;
          hi_ok  = 1'b0;
        end
        decoded_q.push_back(predicted);
      end
    end
    pending <= decoded_q.size();
  end

endmodule

// ===== sim/tb_url_percent_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_url_percent_decoder_core
// Drives encoded strings into the URL percent decoder: a directed set of
// escapes, bad digits and strings that end inside an escape, then random
// strings of text, '+', good and broken escapes, plus raw byte noise. Both
// channels idle in random bursts; the checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder_core;
  import upd_pkg::*;

  localparam int NUM_ITEMS   = 800;
  localparam int QUIET_AFTER = 700;
  localparam int CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       is_last;
  logic       res_valid;
  logic       res_stall;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  int         fail_count;
  int         pending;
  int         cycles = 0;
  int         sent = 0;
  bit         idle_on = 1'b0;

  url_percent_decoder_core dut (.*);
  url_decode_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_0 + {4'd0, v};
    if ($urandom_range(0, 1)) return CH_LA + {4'd0, v} - HEX_TEN;
    return CH_UA + {4'd0, v} - HEX_TEN;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    in_valid <= 1'b1;
    in_byte  <= b;
    is_last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_string(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] bytes[$];
    for (int i = 0; i < s.len(); i++) bytes.push_back(s[i]);
    send_string(bytes);
  endtask

  task automatic send_random_string();
    logic [7:0] bytes[$];
    int         tokens;
    int         kind;
    tokens = $urandom_range(1, 8);
    if ($urandom_range(0, 7) == 0) begin
      // raw noise
      repeat (tokens) bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int t = 0; t < tokens; t++) begin
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
          bytes.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 3) begin
          bytes.push_back(CH_PLUS);
        end else if (kind <= 6) begin
          bytes.push_back(CH_PERCENT);
          bytes.push_back(hex_char(4'($urandom_range(0, 15))));
          bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        end else if (kind == 7) begin
          bytes.push_back(CH_PERCENT);
          bytes.push_back(8'($urandom_range(0, 255)));
          bytes.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 8) begin
          // string ends inside an escape
          bytes.push_back(CH_PERCENT);
          if ($urandom_range(0, 1)) bytes.push_back(hex_char(4'($urandom_range(0, 15))));
          break;
        end else begin
          bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
      end
    end
    send_string(bytes);
  endtask

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_byte  <= '0;
    is_last  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("%4F");
    send_text("%a0+");
    send_text("%G1");
    send_text("%1g");
    send_text("%");
    send_text("%f");
    send_text("%%%");
    send_text("%9a");

    // let everything drain before the random part
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    while (sent < NUM_ITEMS) begin
      idle_on = (sent < QUIET_AFTER) && ((sent / 100) % 3 != 2);
      send_random_string();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
